// ===== src/mrs_pkg.sv =====
// Package for the Modbus RTU read-registers slave.
// Holds sizes, item kinds, function and exception codes and the CRC-16 step.
// No dependencies.
package mrs_pkg;

    localparam int NUM_REGS     = 16;
    localparam int HEADER_DEPTH = 8;
    localparam int RESP_MAX     = 5 + 2 * NUM_REGS;
    localparam int LEN_W        = $clog2(RESP_MAX + 1);
    localparam int REG_W        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int IDX_W        = (REG_W > 4) ? REG_W : 4;
    localparam int HDR_W        = $clog2(HEADER_DEPTH);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    localparam logic [7:0] FUNC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'd16;
    localparam logic [8:0] READ_REQ_LEN            = 9'd8;
    localparam logic [8:0] WRITE_REQ_BASE_LEN      = 9'd9;
    localparam logic [8:0] OTHER_REQUEST_BYTES_NUM = 9'd7;

    localparam logic [7:0] EXC_BAD_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_BAD_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_BAD_VALUE    = 8'd3;
    localparam logic [7:0] EXC_BUSY         = 8'd6;
    localparam logic [7:0] EXC_CRC_MISMATCH = 8'd8;

    localparam logic [LEN_W-1:0] EXC_FRAME_LEN = LEN_W'(5);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READY = 2'd3
    } t_kind;

    typedef struct packed {
        logic take;
        logic decide;
        logic load;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
    } t_stat;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/mrs_ctrl.sv =====
// Controller of the Modbus RTU read-registers slave.
// Sequences item intake, response decision and byte emission; uses mrs_pkg.
module mrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_m_tready,
    input  mrs_pkg::t_stat i_stat,
    output mrs_pkg::t_cmd  o_cmd,
    output logic          o_s_tready
);
    import mrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD,
        S_WAIT
    } t_state;

    t_state r_state;

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_cmd.take     = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.decide   = (r_state == S_DECIDE);
    assign o_cmd.load     = (r_state == S_LOAD);
    assign o_cmd.advance  = (r_state == S_WAIT) && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && i_stat.hit) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: r_state <= S_LOAD;
                S_LOAD:   r_state <= S_WAIT;
                S_WAIT: begin
                    if (i_m_tready) begin
                        r_state <= i_stat.last ? S_IDLE : S_LOAD;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/mrs_dp.sv =====
// Datapath of the Modbus RTU read-registers slave: frame receive, holding
// registers, response decision and byte generation with CRC. Uses mrs_pkg.
module mrs_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mrs_pkg::t_cmd  i_cmd,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_rx_byte,
    input  logic [3:0]    i_reg_index,
    input  logic [15:0]   i_reg_value,
    input  logic [7:0]    i_slave_address,
    input  logic [7:0]    i_gap_ticks,
    output mrs_pkg::t_stat o_stat,
    output logic          o_m_tvalid,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast
);
    import mrs_pkg::*;

    logic [7:0]       r_sil;
    logic             r_open;
    logic [8:0]       r_cnt;
    logic [8:0]       r_explen;
    logic [7:0]       r_hdr [HEADER_DEPTH];
    logic [15:0]      r_hcrc;
    logic [15:0]      r_regs [NUM_REGS];
    logic             r_ready;

    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_fb;
    logic [7:0]       r_third;
    logic [REG_W-1:0] r_ptr;
    logic [15:0]      r_crc;
    logic             r_mvalid;
    logic [7:0]       r_mdata;
    logic             r_mlast;

    logic             gap;
    logic             open_eff;
    logic [8:0]       cnt_eff;
    logic [8:0]       n_explen;
    logic [8:0]       cnt_inc;
    logic             done;
    logic [7:0]       hdr0;
    logic             is_byte;
    logic [IDX_W-1:0] widx;

    logic [15:0]      start;
    logic [15:0]      qty;
    logic [16:0]      span;
    logic [15:0]      rx_crc;
    logic [7:0]       byte_sel;
    logic [15:0]      rd_word;

    assign is_byte = (t_kind'(i_kind) == KIND_BYTE);
    assign gap      = (r_sil > i_gap_ticks);
    assign open_eff = gap || r_open;
    assign cnt_eff  = gap ? 9'd0 : r_cnt;
    assign cnt_inc  = cnt_eff + 9'd1;
    assign hdr0     = (cnt_eff == 9'd0) ? i_rx_byte : r_hdr[0];
    assign widx     = IDX_W'(i_reg_index);

    always_comb begin
        n_explen = gap ? 9'd0 : r_explen;
        if (cnt_eff == 9'd1 && i_rx_byte == FUNC_READ_HOLDING) begin
            n_explen = READ_REQ_LEN;
        end
        if (cnt_eff == 9'd6) begin
            if (r_hdr[1] == FUNC_WRITE_MULTIPLE) begin
                n_explen = WRITE_REQ_BASE_LEN + {1'b0, i_rx_byte};
            end else if (n_explen == 9'd0) begin
                n_explen = OTHER_REQUEST_BYTES_NUM;
            end
        end
    end

    assign done        = is_byte && open_eff && (cnt_inc == n_explen);
    assign o_stat.hit  = done && (hdr0 == i_slave_address);
    assign o_stat.last = r_mlast;

    assign start  = {r_hdr[2], r_hdr[3]};
    assign qty    = {r_hdr[4], r_hdr[5]};
    assign span   = {1'b0, start} + {1'b0, qty};
    assign rx_crc = {r_hdr[7], r_hdr[6]};
    assign rd_word = r_regs[r_ptr];

    always_comb begin
        if (r_idx == LEN_W'(0)) begin
            byte_sel = i_slave_address;
        end else if (r_idx == LEN_W'(1)) begin
            byte_sel = r_fb;
        end else if (r_idx == LEN_W'(2)) begin
            byte_sel = r_third;
        end else if (r_idx == r_len - LEN_W'(2)) begin
            byte_sel = r_crc[7:0];
        end else if (r_idx == r_len - LEN_W'(1)) begin
            byte_sel = r_crc[15:8];
        end else begin
            byte_sel = r_idx[0] ? rd_word[15:8] : rd_word[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_byte && open_eff && cnt_eff < 9'(HEADER_DEPTH)) begin
            r_hdr[cnt_eff[HDR_W-1:0]] <= i_rx_byte;
            if (cnt_eff < 9'd6) begin
                r_hcrc <= crc_step((cnt_eff == 9'd0) ? CRC_INIT : r_hcrc, i_rx_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sil    <= 8'hFF;
            r_open   <= 1'b0;
            r_cnt    <= 9'd0;
            r_explen <= 9'd0;
            r_ready  <= 1'b0;
            r_mvalid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 16'h0000;
            end
        end else begin
            if (i_cmd.take) begin
                case (t_kind'(i_kind))
                    KIND_BYTE: begin
                        r_sil <= 8'h00;
                        if (open_eff) begin
                            if (cnt_inc == n_explen) begin
                                r_open   <= 1'b0;
                                r_cnt    <= 9'd0;
                                r_explen <= 9'd0;
                            end else begin
                                r_open   <= 1'b1;
                                r_cnt    <= cnt_inc;
                                r_explen <= n_explen;
                            end
                        end
                    end
                    KIND_TICK: begin
                        if (r_sil != 8'hFF) begin
                            r_sil <= r_sil + 8'd1;
                        end
                    end
                    KIND_WRITE: begin
                        if (int'(widx) < NUM_REGS) begin
                            r_regs[widx[REG_W-1:0]] <= i_reg_value;
                        end
                    end
                    KIND_READY: r_ready <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.decide) begin
                r_idx <= LEN_W'(0);
                r_crc <= CRC_INIT;
                r_len <= EXC_FRAME_LEN;
                r_fb  <= r_hdr[1] | EXC_FLAG;
                r_ptr <= start[REG_W-1:0];
                if (r_hdr[1] != FUNC_READ_HOLDING) begin
                    r_third <= EXC_BAD_FUNCTION;
                end else if (!r_ready) begin
                    r_third <= EXC_BUSY;
                end else if (r_hcrc != rx_crc) begin
                    r_third <= EXC_CRC_MISMATCH;
                end else if (int'(start) >= NUM_REGS) begin
                    r_third <= EXC_BAD_ADDRESS;
                end else if (qty == 16'd0 || int'(span) > NUM_REGS) begin
                    r_third <= EXC_BAD_VALUE;
                end else begin
                    r_fb    <= FUNC_READ_HOLDING;
                    r_third <= {qty[6:0], 1'b0};
                    r_len   <= EXC_FRAME_LEN + {qty[LEN_W-2:0], 1'b0};
                    r_ready <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_mvalid <= 1'b1;
                r_mdata  <= byte_sel;
                r_mlast  <= (r_idx == r_len - LEN_W'(1));
            end
            if (i_cmd.advance) begin
                r_mvalid <= 1'b0;
                r_idx    <= r_idx + LEN_W'(1);
                if (r_idx < r_len - LEN_W'(2)) begin
                    r_crc <= crc_step(r_crc, r_mdata);
                    if (r_idx >= LEN_W'(4) && !r_idx[0]) begin
                        r_ptr <= r_ptr + REG_W'(1);
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tlast  = r_mlast;

endmodule

// ===== src/modbus_rtu_slave_read_regs.sv =====
// Top level of the Modbus RTU read-registers slave with its APB register port.
// Instantiates mrs_ctrl and mrs_dp; uses mrs_pkg.
//
// The block takes one item per handshake: a received byte, a millisecond tick,
// a holding-register write or a data-ready mark. A received byte that
// completes a request addressed to this slave is followed by a decision state,
// then by a load state and a wait state per response byte, the wait state holding
// while the output stalls (5 bytes for an exception, 5 + 2 * quantity for a read);
// the input stays not ready until the last byte has been taken. The pace is
// set by the byte sequencer and its CRC unit.
// Registers: slave_address at byte address 0, gap_ticks at 4.
module modbus_rtu_slave_read_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // tx_byte[7:0]
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrs_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [7:0] r_slave_address;
    logic [7:0] r_gap_ticks;

    assign pready = 1'b1;
    assign prdata = {24'h000000, paddr[2] ? r_gap_ticks : r_slave_address};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'd1;
            r_gap_ticks     <= 8'd5;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_gap_ticks <= pwdata[7:0];
            end else begin
                r_slave_address <= pwdata[7:0];
            end
        end
    end

    mrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready)
    );

    mrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_s_tuser),
        .i_rx_byte       (i_s_tdata[7:0]),
        .i_reg_index     (i_s_tdata[11:8]),
        .i_reg_value     (i_s_tdata[27:12]),
        .i_slave_address (r_slave_address),
        .i_gap_ticks     (r_gap_ticks),
        .o_stat          (stat),
        .o_m_tvalid      (o_m_tvalid),
        .o_m_tdata       (o_m_tdata),
        .o_m_tlast       (o_m_tlast)
    );

`ifndef SYNTHESIS
    a_no_intake_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a response byte is pending");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> !o_s_tready)
        else $error("input ready in the middle of a response frame");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> o_s_tready && !o_m_tvalid)
        else $error("block not idle after the last response byte");
`endif

endmodule

// ===== verif/modbus_rtu_slave_read_regs_tb.sv =====
// Testbench for the Modbus RTU read-registers slave: drives items and APB writes,
// predicts every response byte and checks it in order.
// Depends on mrs_pkg and modbus_rtu_slave_read_regs.
module modbus_rtu_slave_read_regs_tb;
    import mrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_SLAVE = 3'd0;
    localparam logic [2:0] ADDR_GAP   = 3'd4;

    typedef enum int {
        REQ_GOOD, REQ_BAD_CRC, REQ_BAD_START, REQ_BAD_QTY,
        REQ_FOREIGN, REQ_OTHER_FUN, REQ_WRITE_FUN, REQ_TRUNCATED
    } t_req;

    class mb_scoreboard;
        logic [7:0]  slave_addr = 8'd1;
        logic [7:0]  gap_limit  = 8'd5;
        logic [7:0]  silence    = 8'hFF;
        logic        in_frame   = 1'b0;
        logic [8:0]  rx_count   = '0;
        logic [8:0]  frame_len  = '0;
        logic [7:0]  hdr [HEADER_DEPTH];
        logic [15:0] regs [NUM_REGS];
        logic        ready      = 1'b0;
        logic [8:0]  tx_queue [$];
        int          errors     = 0;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function logic [15:0] crc16(logic [7:0] f[$]);
            logic [15:0] c;
            c = 16'hFFFF;
            foreach (f[i]) begin
                c ^= {8'h00, f[i]};
                for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
            return c;
        endfunction

        function void push_frame(logic [7:0] f[$]);
            logic [15:0] c;
            c = crc16(f);
            f.push_back(c[7:0]);
            f.push_back(c[15:8]);
            foreach (f[i]) tx_queue.push_back({i == f.size() - 1, f[i]});
        endfunction

        function void push_exception(logic [7:0] fun, logic [7:0] code);
            logic [7:0] f[$];
            f = '{slave_addr, fun | 8'h80, code};
            push_frame(f);
        endfunction

        function void answer_read();
            logic [7:0] f[$];
            int start, qty;
            if (!ready) begin
                push_exception(FUNC_READ_HOLDING, EXC_BUSY);
                return;
            end
            for (int i = 0; i < 6; i++) f.push_back(hdr[i]);
            if (crc16(f) != {hdr[7], hdr[6]}) begin
                push_exception(FUNC_READ_HOLDING, EXC_CRC_MISMATCH);
                return;
            end
            start = {hdr[2], hdr[3]};
            qty   = {hdr[4], hdr[5]};
            if (start >= NUM_REGS) begin
                push_exception(FUNC_READ_HOLDING, EXC_BAD_ADDRESS);
                return;
            end
            if (qty == 0 || start + qty > NUM_REGS) begin
                push_exception(FUNC_READ_HOLDING, EXC_BAD_VALUE);
                return;
            end
            f = '{slave_addr, FUNC_READ_HOLDING, 8'(qty * 2)};
            for (int i = start; i < start + qty; i++) begin
                f.push_back(regs[i][15:8]);
                f.push_back(regs[i][7:0]);
            end
            push_frame(f);
            ready = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b);
            if (silence > gap_limit) begin
                in_frame  = 1'b1;
                rx_count  = '0;
                frame_len = '0;
            end
            silence = '0;
            if (!in_frame) return;
            if (rx_count == 1 && b == FUNC_READ_HOLDING) frame_len = READ_REQ_LEN;
            if (rx_count == 6) begin
                if (hdr[1] == FUNC_WRITE_MULTIPLE) frame_len = WRITE_REQ_BASE_LEN + b;
                else if (frame_len == 0) frame_len = OTHER_REQUEST_BYTES_NUM;
            end
            if (rx_count < HEADER_DEPTH) hdr[rx_count[HDR_W-1:0]] = b;
            rx_count = rx_count + 1'b1;
            if (rx_count != frame_len) return;
            rx_count  = '0;
            in_frame  = 1'b0;
            frame_len = '0;
            if (hdr[0] != slave_addr) return;
            if (hdr[1] == FUNC_READ_HOLDING) answer_read();
            else push_exception(hdr[1], EXC_BAD_FUNCTION);
        endfunction

        function void note_item(t_kind k, logic [31:0] d);
            case (k)
                KIND_BYTE:  take_byte(d[7:0]);
                KIND_TICK:  if (silence != 8'hFF) silence++;
                KIND_WRITE: if (d[11:8] < NUM_REGS) regs[d[11:8]] = d[27:12];
                default:    ready = 1'b1;
            endcase
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            logic [8:0] e;
            if (tx_queue.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", b, last));
                return;
            end
            e = tx_queue.pop_front();
            if (b !== e[7:0]) report($sformatf("tx_byte %02h, want %02h", b, e[7:0]));
            if (last !== e[8]) report($sformatf("frame_end %0b, want %0b", last, e[8]));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mb_scoreboard sb = new();
    int burst_left = 0;
    int stall_pct = 0;
    int stall_cycles = 0;
    int item_count = 0;

    modbus_rtu_slave_read_regs dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_cycles == 0) begin
            stall_cycles <= $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_item(t_kind'(i_s_tuser), i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_byte(o_m_tdata, o_m_tlast);
        end
    end

    task automatic send_item(t_kind k, logic [7:0] b, logic [3:0] idx, logic [15:0] val);
        int pause;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            pause = $urandom_range(0, 6);
            if (pause > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= k;
        i_s_tdata  <= {4'h0, val, idx, b};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        item_count++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(KIND_BYTE, b, 4'($urandom), 16'($urandom));
    endtask

    task automatic send_gap();
        int n;
        n = (sb.gap_limit == 8'hFF) ? 3 : sb.gap_limit + 1 + $urandom_range(0, 2);
        repeat (n) send_item(KIND_TICK, 8'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic send_request(t_req r, int start, int qty);
        logic [7:0]  f[$];
        logic [15:0] c;
        logic [7:0]  fun;
        int n;
        send_gap();
        case (r)
            REQ_OTHER_FUN, REQ_WRITE_FUN: begin
                if (r == REQ_WRITE_FUN) fun = FUNC_WRITE_MULTIPLE;
                else begin
                    fun = 8'($urandom);
                    while (fun == FUNC_READ_HOLDING || fun == FUNC_WRITE_MULTIPLE)
                        fun = 8'($urandom);
                end
                f = '{sb.slave_addr, fun};
                repeat (4) f.push_back(8'($urandom));
                n = ($urandom_range(0, 9) == 0) ? 8'($urandom) : $urandom_range(0, 4);
                f.push_back(8'(n));
                if (r == REQ_WRITE_FUN) repeat (n + 2) f.push_back(8'($urandom));
            end
            REQ_TRUNCATED: repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
            default: begin
                f = '{(r == REQ_FOREIGN) ? sb.slave_addr + 8'($urandom_range(1, 255))
                                         : sb.slave_addr,
                      FUNC_READ_HOLDING, 8'(start >> 8), 8'(start), 8'(qty >> 8), 8'(qty)};
                c = sb.crc16(f);
                if (r == REQ_BAD_CRC) c ^= 16'(1 << $urandom_range(0, 15));
                f.push_back(c[7:0]);
                f.push_back(c[15:8]);
            end
        endcase
        foreach (f[i]) send_byte(f[i]);
    endtask

    task automatic random_request();
        int start, qty, p;
        start = $urandom_range(0, NUM_REGS - 1);
        qty   = $urandom_range(1, NUM_REGS - start);
        if ($urandom_range(0, 2) == 0)
            send_item(KIND_WRITE, 8'($urandom), 4'($urandom), 16'($urandom));
        if ($urandom_range(0, 9) < 7)
            send_item(KIND_READY, 8'($urandom), 4'($urandom), 16'($urandom));
        p = $urandom_range(0, 99);
        if (p < 55) send_request(REQ_GOOD, start, qty);
        else if (p < 61) send_request(REQ_BAD_CRC, start, qty);
        else if (p < 67) send_request(REQ_BAD_START, $urandom_range(NUM_REGS, 65535), qty);
        else if (p < 73)
            send_request(REQ_BAD_QTY, start, ($urandom_range(0, 1) == 0) ? 0
                         : $urandom_range(NUM_REGS - start + 1, 65535));
        else if (p < 79) send_request(REQ_FOREIGN, start, qty);
        else if (p < 86) send_request(REQ_OTHER_FUN, 0, 0);
        else if (p < 92) send_request(REQ_WRITE_FUN, 0, 0);
        else send_request(REQ_TRUNCATED, 0, 0);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.tx_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_SLAVE) sb.slave_addr = value;
        else sb.gap_limit = value;
    endtask

    initial begin
        logic [7:0] addrs [6];
        logic [7:0] gaps  [6];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_WRITE, 8'h00, 4'h0, 16'h0000);
        send_item(KIND_WRITE, 8'hFF, 4'hF, 16'hFFFF);
        send_item(KIND_WRITE, 8'h5A, 4'h7, 16'hA5C3);
        send_request(REQ_GOOD, 0, NUM_REGS);
        send_item(KIND_READY, 8'h00, 4'h0, 16'h0000);
        send_request(REQ_GOOD, 0, NUM_REGS);
        send_item(KIND_READY, 8'hFF, 4'hF, 16'hFFFF);
        send_request(REQ_BAD_CRC, 3, 2);
        send_request(REQ_BAD_START, 65535, 1);
        send_request(REQ_BAD_QTY, 0, 0);
        send_request(REQ_BAD_QTY, NUM_REGS - 1, 2);
        send_request(REQ_GOOD, NUM_REGS - 1, 1);
        send_request(REQ_OTHER_FUN, 0, 0);
        send_request(REQ_WRITE_FUN, 0, 0);
        send_request(REQ_FOREIGN, 0, 1);
        wait_drained();

        addrs = '{8'h00, 8'hFF, 8'h01, 8'h5C, 8'hA3, 8'h01};
        gaps  = '{8'h00, 8'hFF, 8'h05, 8'h02, 8'h0E, 8'h05};
        for (int ph = 0; ph < 6; ph++) begin
            apb_write(ADDR_SLAVE, addrs[ph]);
            apb_write(ADDR_GAP, gaps[ph]);
            for (int j = 0; j < 2; j++) begin
                random_request();
                if (ph == 2 && j == 0) wait_drained();
            end
            wait_drained();
        end
        while (item_count < 360) random_request();
        wait_drained();

        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mrs_pkg.sv
src/mrs_ctrl.sv
src/mrs_dp.sv
src/modbus_rtu_slave_read_regs.sv
verif/modbus_rtu_slave_read_regs_tb.sv
